// ===== sv/gra_pkg.sv =====
`timescale 1ns / 1ps

package gra_pkg;

  localparam int HISTORY_DEPTH = 9;
  localparam int RING_DEPTH    = HISTORY_DEPTH + 1;
  localparam int HIST_AW       = $clog2(RING_DEPTH);

  localparam int GYRO_W     = 24;
  localparam int OFFSET_W   = 24;
  localparam int WIN_W      = 4;
  localparam int URATE_W    = 10;
  localparam int RATE_W     = 32;
  localparam int SPEED_W    = 32;
  localparam int ACC_W      = 40;
  localparam int HEAD_W     = 25;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int WIN_MAX = (HISTORY_DEPTH > (2 ** WIN_W - 1)) ? (2 ** WIN_W - 1) : HISTORY_DEPTH;

  localparam int DIFF_W    = GYRO_W + 1;
  localparam int K_W       = 30;
  localparam int PROD_W    = DIFF_W + K_W + 1;
  localparam int SUM_W     = RATE_W + $clog2(HISTORY_DEPTH);
  localparam int ACC_RAW_W = (RATE_W + 1) + (URATE_W + 1);
  localparam int HP_W      = 34;

  localparam int NUM_W     = 46;
  localparam int DEN_W     = 25;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // a full turn is 45 * 2^19 in Q9.16; fold by the upper bits with a reciprocal multiply
  localparam int WRAP_SH  = 19;
  localparam int WRAP_YW  = HP_W - WRAP_SH + 1;
  localparam int WRAP_RSH = 21;
  localparam int WRAP_QW  = 2 * WRAP_YW - WRAP_RSH;
  localparam int WRAP_RW  = HEAD_W - WRAP_SH;

  localparam logic [K_W-1:0]        RAD2DEG_Q24 = 30'd961263669;
  localparam logic [PROD_W-1:0]     ROUND_Q24   = PROD_W'(2 ** 23);
  localparam logic [HEAD_W-1:0]     HALF_TURN   = 25'd11796480;
  localparam logic [WRAP_YW-1:0]    WRAP_DIV    = WRAP_YW'(45);
  localparam logic [WRAP_YW-1:0]    WRAP_BIAS   = WRAP_YW'(16425);
  localparam logic [WRAP_YW-1:0]    WRAP_RECIP  = WRAP_YW'(46604);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_OFFSET = 8'd0,
    CFG_INVERT_RATE = 8'd1,
    CFG_WINDOW_LEN  = 8'd2,
    CFG_UPDATE_RATE = 8'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_RATE,
    ST_READ,
    ST_DRAIN,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WRAP,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_SPEED,
    OP_ACC,
    OP_HEAD
  } div_op_e;

  typedef struct packed {
    logic               push;
    logic [RATE_W-1:0]  wdata;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_off;
  } hist_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/gra_in_if.sv =====
`timescale 1ns / 1ps

interface gra_in_if import gra_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GYRO_W-1:0] gyro_z;

  modport source (output valid, output gyro_z, input ready);
  modport sink   (input valid, input gyro_z, output ready);
endinterface

// ===== sv/gra_out_if.sv =====
`timescale 1ns / 1ps

interface gra_out_if import gra_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] rot_speed;
  logic signed [ACC_W-1:0]   rot_acc;
  logic signed [HEAD_W-1:0]  heading_change;

  modport source (output valid, output rot_speed, output rot_acc, output heading_change,
                  input ready);
  modport sink   (input valid, input rot_speed, input rot_acc, input heading_change,
                  output ready);
endinterface

// ===== sv/gra_cfg_if.sv =====
`timescale 1ns / 1ps

interface gra_cfg_if import gra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/gra_div.sv =====
`timescale 1ns / 1ps

module gra_div import gra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_d;
  logic [NUM_W-1:0]  quo_d;

  // two restoring steps per cycle
  always_comb begin
    logic [DEN_W-1:0] r;
    logic [NUM_W-1:0] q;
    logic [DEN_W:0]   t;
    r = rem_q;
    q = quo_q;
    t = '0;
    for (int s = 0; s < 2; s++) begin
      t = {r, q[NUM_W-1]};
      q = {q[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t    = t - {1'b0, den_q};
        q[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // floor division: fold a negative dividend with one's complement
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[NUM_W-1];
      quo_q <= req_i.num[NUM_W-1] ? ~req_i.num : req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? ~quo_q : quo_q;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(busy_q) |-> $past(req_i.start))
    else $error("divider started without request");
`endif

endmodule

// ===== sv/gra_hist.sv =====
`timescale 1ns / 1ps

module gra_hist import gra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hist_req_t         req_i,
  output logic [RATE_W-1:0] rd_data_o
);

  logic [RATE_W-1:0]     mem_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;
  logic [HIST_AW-1:0]    wp_q;
  logic [HIST_AW-1:0]    wp_d;
  logic [HIST_AW-1:0]    rd_addr;
  logic [HIST_AW:0]      rd_wrap;
  logic [RATE_W-1:0]     rdata_q;
  logic                  rvalid_q;

  assign wp_d    = (wp_q == HIST_AW'(RING_DEPTH - 1)) ? '0 : wp_q + HIST_AW'(1);
  assign rd_wrap = {1'b0, wp_q} + (HIST_AW + 1)'(RING_DEPTH) - {1'b0, req_i.rd_off};
  assign rd_addr = (wp_q >= req_i.rd_off) ? (wp_q - req_i.rd_off) : rd_wrap[HIST_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wp_d] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.push) begin
        wp_q          <= wp_d;
        valid_q[wp_d] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[rd_addr];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rvalid_q ? rdata_q : '0;

`ifndef SYNTHESIS
  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= HIST_AW'(RING_DEPTH - 1))
    else $error("history pointer outside ring");

  a_no_push_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.push && req_i.rd_en))
    else $error("history push and read overlap");
`endif

endmodule

// ===== sv/gyro_rate_average_heading.sv =====
`timescale 1ns / 1ps

// Yaw-rate averager and heading integrator. Each request carries one Q8.16 rad/s sample; the
// block removes the offset, converts to Q16.16 deg/s, pushes it into a ring memory of the newest
// HISTORY_DEPTH+1 rates and returns the windowed mean rate, the saturated mean rate change and
// the heading wrapped to [-180,180). One sample is processed at a time: after the sample is accepted,
// the block reads n history entries, n being the effective window, then runs three divisions on
// the shared radix-4 divider and wraps the heading in the wrap and fold states. The next sample
// is accepted once the result is loaded, while that result may still wait; a result that finds
// the previous one still waiting holds until it is taken. Configuration writes are always ready.

module gyro_rate_average_heading import gra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gra_in_if.sink    in_i,
  gra_out_if.source res_o,
  gra_cfg_if.sink   cfg_i
);

  state_e  state_q, state_d;
  div_op_e op_q, op_d;

  logic [OFFSET_W-1:0] offset_q;
  logic                invert_q;
  logic [WIN_W-1:0]    win_q;
  logic [URATE_W-1:0]  urate_q;

  logic [WIN_W-1:0]    n_eff;
  logic [URATE_W-1:0]  f_eff;
  logic [HIST_AW-1:0]  n_off;

  logic [HIST_AW-1:0]  rd_cnt_q;
  logic [HIST_AW-1:0]  rd_idx_q;
  logic                rd_pend_q;
  logic [RATE_W-1:0]   rd_data;

  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [K_W:0]      k_s;
  logic signed [PROD_W-1:0] prod_d;
  logic [RATE_W-1:0]        rate_abs;
  logic [RATE_W-1:0]        rate_d;
  logic [RATE_W-1:0]        rate_q;
  logic [SUM_W-1:0]         sum_q;
  logic [RATE_W-1:0]        old_q;
  logic signed [RATE_W:0]   rate_dlt;
  logic signed [URATE_W:0]  f_s;
  logic signed [ACC_RAW_W-1:0] acc_d;
  logic [ACC_RAW_W-1:0]     acc_q;

  logic [SPEED_W-1:0] speed_q;
  logic [ACC_W-1:0]   acc_res_q;
  logic [ACC_W-1:0]   acc_sat;
  logic [HP_W-1:0]    head_pre_q;
  logic [HEAD_W-1:0]  heading_q;
  logic [HEAD_W:0]    head_wrap;

  logic [WRAP_YW-1:0]   wrap_y;
  logic [2*WRAP_YW-1:0] wrap_prod;
  logic [WRAP_QW-1:0]   wrap_q;
  logic [WRAP_RW-1:0]   wrap_rem;

  logic               out_valid_q;
  logic               out_load;
  logic [SPEED_W-1:0] out_speed_q;
  logic [ACC_W-1:0]   out_acc_q;
  logic [HEAD_W-1:0]  out_head_q;

  hist_req_t hist_req;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  gra_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hist_req),
    .rd_data_o (rd_data)
  );

  gra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      invert_q <= 1'b0;
      win_q    <= WIN_W'(3);
      urate_q  <= URATE_W'(50);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_GYRO_OFFSET: offset_q <= cfg_i.data[OFFSET_W-1:0];
        CFG_INVERT_RATE: invert_q <= cfg_i.data[0];
        CFG_WINDOW_LEN:  win_q    <= cfg_i.data[WIN_W-1:0];
        CFG_UPDATE_RATE: urate_q  <= cfg_i.data[URATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (win_q == '0) ? WIN_W'(1) :
                 (win_q > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : win_q;
  assign f_eff = (urate_q == '0) ? URATE_W'(1) : urate_q;
  assign n_off = HIST_AW'(n_eff);

  // datapath arithmetic
  assign k_s      = {1'b0, RAD2DEG_Q24};
  assign prod_d   = diff_q * k_s;
  assign prod_rnd = prod_q + $signed(ROUND_Q24);
  assign rate_abs = prod_rnd[RATE_W+23:24];
  assign rate_d   = invert_q ? (RATE_W'(0) - rate_abs) : rate_abs;

  assign rate_dlt = $signed({rate_q[RATE_W-1], rate_q}) - $signed({old_q[RATE_W-1], old_q});
  assign f_s      = $signed({1'b0, f_eff});
  assign acc_d    = rate_dlt * f_s;

  assign acc_sat = ((&div_rsp.quot[NUM_W-1:ACC_W-1]) || !(|div_rsp.quot[NUM_W-1:ACC_W-1])) ?
                   div_rsp.quot[ACC_W-1:0] :
                   (div_rsp.quot[NUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} :
                                            {1'b0, {(ACC_W-1){1'b1}}});

  // heading wrap: biased turn count from the upper bits, then the remainder in those bits
  assign wrap_y    = {head_pre_q[HP_W-1], head_pre_q[HP_W-1:WRAP_SH]} + WRAP_BIAS;
  assign wrap_prod = wrap_y * WRAP_RECIP;
  assign wrap_rem  = WRAP_RW'(wrap_y - WRAP_YW'(wrap_q) * WRAP_DIV);
  assign head_wrap = {1'b0, wrap_rem, head_pre_q[WRAP_SH-1:0]} - {1'b0, HALF_TURN};

  // divider operand select
  always_comb begin
    div_req.start = (state_q == ST_DIV_GO);
    case (op_q)
      OP_SPEED: begin
        div_req.num = {{(NUM_W-SUM_W-1){sum_q[SUM_W-1]}}, sum_q, 1'b0} + NUM_W'(n_eff);
        div_req.den = DEN_W'({n_eff, 1'b0});
      end
      OP_ACC: begin
        div_req.num = {{(NUM_W-ACC_RAW_W-1){acc_q[ACC_RAW_W-1]}}, acc_q, 1'b0} + NUM_W'(n_eff);
        div_req.den = DEN_W'({n_eff, 1'b0});
      end
      default: begin
        div_req.num = {{(NUM_W-RATE_W-1){rate_q[RATE_W-1]}}, rate_q, 1'b0} + NUM_W'(f_eff);
        div_req.den = DEN_W'({f_eff, 1'b0});
      end
    endcase
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_CONV;
      ST_CONV:  state_d = ST_RATE;
      ST_RATE:  state_d = ST_READ;
      ST_READ:  if (rd_cnt_q == n_off) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_ACC;
      ST_ACC: begin
        state_d = ST_DIV_GO;
        op_d    = OP_SPEED;
      end
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (op_q)
            OP_SPEED: begin
              op_d    = OP_ACC;
              state_d = ST_DIV_GO;
            end
            OP_ACC: begin
              op_d    = OP_HEAD;
              state_d = ST_DIV_GO;
            end
            default: state_d = ST_WRAP;
          endcase
        end
      end
      ST_WRAP: state_d = ST_FOLD;
      ST_FOLD: state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready      = (state_q == ST_IDLE);
    hist_req.push   = (state_q == ST_RATE);
    hist_req.wdata  = rate_d;
    hist_req.rd_en  = (state_q == ST_READ);
    hist_req.rd_off = rd_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SPEED;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      heading_q   <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      rd_pend_q <= (state_q == ST_READ);
      if (state_q == ST_RATE) begin
        rd_cnt_q <= HIST_AW'(1);
      end else if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + HIST_AW'(1);
      end
      if (state_q == ST_FOLD) begin
        heading_q <= head_wrap[HEAD_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      diff_q <= $signed({in_i.gyro_z[GYRO_W-1], in_i.gyro_z}) -
                $signed({offset_q[OFFSET_W-1], offset_q});
    end
    if (state_q == ST_CONV) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_RATE) begin
      rate_q <= rate_d;
      sum_q  <= {{(SUM_W-RATE_W){rate_d[RATE_W-1]}}, rate_d};
    end
    rd_idx_q <= rd_cnt_q;
    // hold the oldest entry aside for the rate change
    if (rd_pend_q) begin
      if (rd_idx_q == n_off) begin
        old_q <= rd_data;
      end else begin
        sum_q <= sum_q + {{(SUM_W-RATE_W){rd_data[RATE_W-1]}}, rd_data};
      end
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      case (op_q)
        OP_SPEED: speed_q   <= div_rsp.quot[SPEED_W-1:0];
        OP_ACC:   acc_res_q <= acc_sat;
        OP_HEAD:  head_pre_q <= {{(HP_W-HEAD_W){heading_q[HEAD_W-1]}}, heading_q} +
                                div_rsp.quot[HP_W-1:0] + HP_W'(HALF_TURN);
        default: ;
      endcase
    end
    if (state_q == ST_WRAP) begin
      wrap_q <= WRAP_QW'(wrap_prod >> WRAP_RSH);
    end
    if (out_load) begin
      out_speed_q <= speed_q;
      out_acc_q   <= acc_res_q;
      out_head_q  <= heading_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.rot_speed      = out_speed_q;
  assign res_o.rot_acc        = out_acc_q;
  assign res_o.heading_change = out_head_q;

`ifndef SYNTHESIS
  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

  a_heading_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(heading_q) >= $signed(-HALF_TURN) && $signed(heading_q) < $signed(HALF_TURN))
    else $error("heading outside half-turn range");
`endif

endmodule

// ===== tb/gyro_rate_average_heading_tb.sv =====
`timescale 1ns / 1ps

module gyro_rate_average_heading_tb;
  import gra_pkg::*;

  localparam longint RAD2DEG_K    = 64'sd961263669;
  localparam longint TURN_HALF    = 64'sd11796480;
  localparam longint TURN_FULL    = 64'sd23592960;
  localparam longint ACC_HI       = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_LO       = -(64'sd1 <<< (ACC_W - 1));
  localparam int     RANDOM_ITEMS = 1900;
  localparam int     CALM_TAIL    = 300;
  localparam int     DRAIN_CYCLES = 150;
  localparam int     LIMIT_CYCLES = 1500000;

  localparam logic signed [GYRO_W-1:0]  GYRO_MAX        = {1'b0, {(GYRO_W - 1){1'b1}}};
  localparam logic signed [GYRO_W-1:0]  GYRO_MIN        = {1'b1, {(GYRO_W - 1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0]      CFG_FIRST_SPARE = CFG_UPDATE_RATE + 1;
  localparam logic [CFG_IDX_W-1:0]      CFG_LAST_SPARE  = {CFG_IDX_W{1'b1}};

  typedef struct {
    logic signed [SPEED_W-1:0] speed;
    logic signed [ACC_W-1:0]   acc;
    logic signed [HEAD_W-1:0]  head;
  } motion_t;

  logic clk_i;
  logic rst_ni;

  gra_in_if  in_bus();
  gra_out_if res_bus();
  gra_cfg_if cfg_bus();

  gyro_rate_average_heading uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  logic [OFFSET_W-1:0]       offset_reg = '0;
  logic                      invert_reg = 1'b0;
  logic [WIN_W-1:0]          win_reg    = WIN_W'(3);
  logic [URATE_W-1:0]        urate_reg  = URATE_W'(50);
  logic signed [RATE_W-1:0]  rate_hist [RING_DEPTH];
  longint                    heading_acc = 0;

  logic signed [GYRO_W-1:0]  sample_q [$];
  motion_t                   motion_q [$];

  bit quiet = 1'b0;
  int errors = 0;
  int samples_taken = 0;
  int results_checked = 0;
  int settings_used = 1;
  int cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_nearest(longint a, longint d);
    return floor_div(2 * a + d, 2 * d);
  endfunction

  function automatic motion_t predict_motion(logic signed [GYRO_W-1:0] z);
    longint  delta, rate, total, acc, head, f;
    int      n;
    motion_t m;
    delta = longint'(z) - longint'($signed(offset_reg));
    rate  = (delta * RAD2DEG_K + (64'sd1 <<< 23)) >>> 24;
    if (invert_reg) rate = -rate;
    for (int i = 0; i < HISTORY_DEPTH; i++) rate_hist[i] = rate_hist[i + 1];
    rate_hist[HISTORY_DEPTH] = RATE_W'(rate);
    n = win_reg;
    if (n < 1) n = 1;
    if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;
    f = urate_reg;
    if (f < 1) f = 1;
    total = 0;
    for (int i = 0; i < n; i++) total += longint'(rate_hist[HISTORY_DEPTH - i]);
    acc = (longint'(rate_hist[HISTORY_DEPTH]) - longint'(rate_hist[HISTORY_DEPTH - n])) * f;
    acc = round_nearest(acc, longint'(n));
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    head = heading_acc + round_nearest(rate, f) + TURN_HALF;
    head = head - floor_div(head, TURN_FULL) * TURN_FULL - TURN_HALF;
    heading_acc = head;
    m.speed = SPEED_W'(round_nearest(total, longint'(n)));
    m.acc   = ACC_W'(acc);
    m.head  = HEAD_W'(head);
    return m;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned value, int width);
    return CFG_DATA_W'(($urandom() << width) | value);
  endfunction

  // request driver
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        motion_q.push_back(predict_motion(in_bus.gyro_z));
        samples_taken++;
      end
      if (in_bus.valid && !in_bus.ready) begin
      end else if (gap_left > 0) begin
        in_bus.valid <= 1'b0;
        gap_left--;
      end else if (sample_q.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_bus.valid <= 1'b0;
        gap_left = $urandom_range(0, 3);
      end else begin
        in_bus.valid  <= 1'b1;
        in_bus.gyro_z <= sample_q.pop_front();
      end
    end
  end

  // result monitor
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    motion_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (motion_q.size() == 0) begin
          $display("%0t: result with no request pending", $time);
          errors++;
        end else begin
          want = motion_q.pop_front();
          results_checked++;
          if (res_bus.rot_speed !== want.speed) begin
            $display("%0t: rot_speed expected %0d got %0d", $time, want.speed,
                     res_bus.rot_speed);
            errors++;
          end
          if (res_bus.rot_acc !== want.acc) begin
            $display("%0t: rot_acc expected %0d got %0d", $time, want.acc, res_bus.rot_acc);
            errors++;
          end
          if (res_bus.heading_change !== want.head) begin
            $display("%0t: heading_change expected %0d got %0d", $time, want.head,
                     res_bus.heading_change);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, motion_q.size());
      $display("gyro_rate_average_heading test failed");
      $finish;
    end
  end

  task automatic settle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_bus.valid || motion_q.size() != 0);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] off_d, inv_d, win_d, rate_d);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] dat [5];
    idx[0] = CFG_GYRO_OFFSET;
    idx[1] = CFG_INVERT_RATE;
    idx[2] = CFG_WINDOW_LEN;
    idx[3] = CFG_UPDATE_RATE;
    idx[4] = CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE));
    dat[0] = off_d;
    dat[1] = inv_d;
    dat[2] = win_d;
    dat[3] = rate_d;
    dat[4] = CFG_DATA_W'($urandom());
    @(posedge clk_i);
    for (int k = 0; k < 5; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= dat[k];
      do @(posedge clk_i);
      while (!cfg_bus.ready);
      case (idx[k])
        CFG_GYRO_OFFSET: offset_reg = dat[k][OFFSET_W-1:0];
        CFG_INVERT_RATE: invert_reg = dat[k][0];
        CFG_WINDOW_LEN:  win_reg    = dat[k][WIN_W-1:0];
        CFG_UPDATE_RATE: urate_reg  = dat[k][URATE_W-1:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic start_phase(input logic [CFG_DATA_W-1:0] off_d, inv_d, win_d, rate_d,
                             input bit calm);
    settle();
    write_regs(off_d, inv_d, win_d, rate_d);
    @(negedge clk_i);
    quiet = calm;
  endtask

  initial begin
    int unsigned           n;
    int                    queued;
    logic [OFFSET_W-1:0]   off_v;
    int unsigned           win_v, rate_v;
    logic signed [GYRO_W-1:0] s;
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.gyro_z = '0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    for (int i = 0; i < RING_DEPTH; i++) rate_hist[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    sample_q = {24'sd0, GYRO_MAX, GYRO_MIN, 24'sd1, -24'sd1};

    start_phase(GYRO_MAX, 24'd1, 24'd9, 24'd1, 1'b0);
    sample_q = {GYRO_MIN, GYRO_MAX, GYRO_MIN, 24'sd0, GYRO_MAX, 24'sh2AAAAA};

    start_phase(GYRO_MIN, 24'd0, 24'd1, 24'd1023, 1'b0);
    sample_q = {GYRO_MAX, GYRO_MIN, GYRO_MAX, GYRO_MIN};

    start_phase(24'd0, 24'hFFFFFE, 24'hFFFFF0, 24'hFFFC00, 1'b1);
    sample_q = {24'sh2AAAAA, 24'shD55555, 24'sd1000};

    start_phase(CFG_DATA_W'($urandom()), 24'hFFFFFF, 24'hF0000F, 24'd1000, 1'b0);
    sample_q = {GYRO_MAX, 24'sd7, GYRO_MIN};

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       off_v = '0;
        1:       off_v = GYRO_MAX;
        2:       off_v = GYRO_MIN;
        default: off_v = OFFSET_W'($urandom());
      endcase
      win_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                          : $urandom_range(1, HISTORY_DEPTH);
      case ($urandom_range(0, 5))
        0:       rate_v = $urandom_range(0, 1023);
        1:       rate_v = 1;
        2:       rate_v = 1000;
        default: rate_v = $urandom_range(1, 1000);
      endcase
      start_phase(off_v, with_noise($urandom_range(0, 1), 1), with_noise(win_v, WIN_W),
                  with_noise(rate_v, URATE_W),
                  (queued > RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 4) == 0));
      n = $urandom_range(90, 180);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       s = $urandom_range(0, 1) ? GYRO_MAX : GYRO_MIN;
          1, 2, 3: s = GYRO_W'(off_v + $urandom_range(0, 2047) - 1024);
          default: s = GYRO_W'($urandom());
        endcase
        sample_q.push_back(s);
      end
      queued += n;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d results from %0d samples across %0d register settings,",
             results_checked, samples_taken, settings_used);
    $display("including window, rate and offset extremes and rate-change saturation.");
    if (errors == 0 && motion_q.size() == 0) begin
      $display("gyro_rate_average_heading test passed");
    end else begin
      $display("gyro_rate_average_heading test failed");
    end
    $finish;
  end

endmodule

// ===== gyro_rate_average_heading.f =====
sv/gra_pkg.sv
sv/gra_in_if.sv
sv/gra_out_if.sv
sv/gra_cfg_if.sv
sv/gra_div.sv
sv/gra_hist.sv
sv/gyro_rate_average_heading.sv
tb/gyro_rate_average_heading_tb.sv
